FILE: design/mqsm_pkg.sv
package mqsm_pkg;

  localparam int DEF_NUM_QUEUES    = 4;
  localparam int DEF_SEGMENT_DEPTH = 32;
  localparam int DEF_DATA_WIDTH    = 32;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BADQ  = 2'd3;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // address width for n entries, never below one bit
  function automatic int addr_width(input int n);
    addr_width = (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

FILE: design/mqsm_ptr_mem.sv
module mqsm_ptr_mem
  import mqsm_pkg::*;
#(
  parameter int NUM_QUEUES = DEF_NUM_QUEUES,
  parameter int PW         = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              rd_en,
  input  logic [addr_width(NUM_QUEUES)-1:0] rd_addr,
  output logic [2*PW:0]                     rd_data,  // tail, head, empty flag on top
  input  logic                              wr_en,
  input  logic [addr_width(NUM_QUEUES)-1:0] wr_addr,
  input  logic [2*PW:0]                     wr_data
);

  localparam int EW = 2 * PW + 1;

  logic [EW-1:0]         mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] valid;
  logic [EW-1:0]         rdata;
  logic                  rvalid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid <= valid[rd_addr];
      end
    end
  end

  // an entry never written reads as an empty queue with both pointers at zero
  assign rd_data = rvalid ? rdata : {1'b1, {(2 * PW){1'b0}}};

endmodule

FILE: design/mqsm_data_mem.sv
module mqsm_data_mem
  import mqsm_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int DEPTH      = DEF_NUM_QUEUES * DEF_SEGMENT_DEPTH
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [addr_width(DEPTH)-1:0] wr_addr,
  input  logic [DATA_WIDTH-1:0]        wr_data,
  input  logic                         rd_en,
  input  logic [addr_width(DEPTH)-1:0] rd_addr,
  output logic [DATA_WIDTH-1:0]        rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/multi_queue_shared_memory_core.sv
// Several circular queues sharing one data memory; queue q owns a fixed
// segment of SEGMENT_DEPTH words. Input beats on the s_ channel carry the
// command in s_tuser (0 enqueue, 1 dequeue) and the queue index and value in
// s_tdata. Each input beat yields exactly one output beat on the m_ channel:
// the status code in m_tuser, the dequeued word (zero unless a dequeue
// succeeded) and the echoed queue index in m_tdata.
// An item is handled in order: pointer memory read, pointer update with
// the data memory access, then the data memory read word is taken into the
// output register, which drives m_tvalid. A new input beat is taken only
// after the previous item has reached the output register. The registered
// reads of the pointer memory and of the data memory set this sequence.
// The output register holds a finished beat while the next item is already
// being worked on; if the receiver stalls, that item waits in its last step
// and s_tready stays low until the output register frees.
// Reset (rst, synchronous) marks every queue empty at once; no clearing pass.
// s_tready stays low while rst is high.
module multi_queue_shared_memory_core
  import mqsm_pkg::*;
#(
  parameter int NUM_QUEUES    = DEF_NUM_QUEUES,
  parameter int SEGMENT_DEPTH = DEF_SEGMENT_DEPTH,
  parameter int DATA_WIDTH    = DEF_DATA_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // queue_index[1:0], value[33:2], zero pad
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // dequeued_value[31:0], queue_echo[33:32], zero pad
  output logic [1:0]  m_tuser    // status
);

  localparam int QW    = addr_width(NUM_QUEUES);
  localparam int PW    = addr_width(SEGMENT_DEPTH);
  localparam int DEPTH = NUM_QUEUES * SEGMENT_DEPTH;
  localparam int AW    = addr_width(DEPTH);
  localparam int EW    = 2 * PW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PTR  = 2'd1;
  localparam logic [1:0] S_DAT  = 2'd2;

  logic [1:0]  state;
  logic [1:0]  state_next;
  logic        cmd;
  logic [1:0]  qidx;
  logic [31:0] val;
  logic [1:0]  status;
  logic        deq_ok;

  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_value;
  logic [1:0]  out_echo;

  logic          in_fire;
  logic          q_valid_in;
  logic          q_valid;
  logic [QW-1:0] q_addr;

  logic          ptr_rd_en;
  logic [EW-1:0] ptr_rd_data;
  logic          ptr_wr_en;
  logic [EW-1:0] ptr_wr_data;

  logic          dm_wr_en;
  logic          dm_rd_en;
  logic [AW-1:0] dm_addr;
  logic [DATA_WIDTH-1:0] dm_rd_data;

  logic          cur_empty;
  logic [PW-1:0] cur_head;
  logic [PW-1:0] cur_tail;
  logic [PW-1:0] tail_inc;
  logic [PW-1:0] head_inc;
  logic [AW-1:0] seg_base;
  logic [1:0]    status_next;
  logic          deq_ok_next;
  logic          out_load;

  assign s_tready   = (state == S_IDLE) && !rst;
  assign in_fire    = s_tvalid && s_tready;
  assign q_valid_in = (int'(s_tdata[1:0]) < NUM_QUEUES);
  assign q_valid    = (int'(qidx) < NUM_QUEUES);
  assign q_addr     = QW'(qidx);
  assign ptr_rd_en  = in_fire && q_valid_in;

  mqsm_ptr_mem #(
    .NUM_QUEUES (NUM_QUEUES),
    .PW         (PW)
  ) u_ptr_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (ptr_rd_en),
    .rd_addr (QW'(s_tdata[1:0])),
    .rd_data (ptr_rd_data),
    .wr_en   (ptr_wr_en),
    .wr_addr (q_addr),
    .wr_data (ptr_wr_data)
  );

  mqsm_data_mem #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (DEPTH)
  ) u_data_mem (
    .clk     (clk),
    .wr_en   (dm_wr_en),
    .wr_addr (dm_addr),
    .wr_data (DATA_WIDTH'(val)),
    .rd_en   (dm_rd_en),
    .rd_addr (dm_addr),
    .rd_data (dm_rd_data)
  );

  assign cur_empty = ptr_rd_data[EW-1];
  assign cur_head  = ptr_rd_data[2*PW-1:PW];
  assign cur_tail  = ptr_rd_data[PW-1:0];
  assign tail_inc  = (cur_tail == PW'(SEGMENT_DEPTH - 1)) ? '0 : cur_tail + 1'b1;
  assign head_inc  = (cur_head == PW'(SEGMENT_DEPTH - 1)) ? '0 : cur_head + 1'b1;
  assign seg_base  = AW'(q_addr) * AW'(SEGMENT_DEPTH);

  // pointer update and data memory access, all in the S_PTR cycle
  always_comb begin
    ptr_wr_en   = 1'b0;
    ptr_wr_data = ptr_rd_data;
    dm_wr_en    = 1'b0;
    dm_rd_en    = 1'b0;
    dm_addr     = seg_base;
    status_next = ST_OK;
    deq_ok_next = 1'b0;
    if (state == S_PTR) begin
      priority if (!q_valid) begin
        status_next = ST_BADQ;
      end else if (cmd == CMD_ENQ && cur_empty) begin
        ptr_wr_en   = 1'b1;
        ptr_wr_data = {1'b0, {(2 * PW){1'b0}}};
        dm_wr_en    = 1'b1;
      end else if (cmd == CMD_ENQ && tail_inc == cur_head) begin
        status_next = ST_FULL;
      end else if (cmd == CMD_ENQ) begin
        ptr_wr_en   = 1'b1;
        ptr_wr_data = {1'b0, cur_head, tail_inc};
        dm_wr_en    = 1'b1;
        dm_addr     = seg_base + AW'(tail_inc);
      end else if (cur_empty) begin
        status_next = ST_EMPTY;
      end else begin
        ptr_wr_en   = 1'b1;
        ptr_wr_data = (cur_head == cur_tail) ? {1'b1, cur_head, cur_tail}
                                             : {1'b0, head_inc, cur_tail};
        dm_rd_en    = 1'b1;
        dm_addr     = seg_base + AW'(cur_head);
        deq_ok_next = 1'b1;
      end
    end
  end

  assign out_load = (state == S_DAT) && (!out_valid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_fire) state_next = S_PTR;
      S_PTR:   state_next = S_DAT;
      S_DAT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd  <= s_tuser;
      qidx <= s_tdata[1:0];
      val  <= s_tdata[33:2];
    end
    if (state == S_PTR) begin
      status <= status_next;
      deq_ok <= deq_ok_next;
    end
    if (out_load) begin
      out_status <= status;
      out_value  <= deq_ok ? 32'(dm_rd_data) : 32'd0;
      out_echo   <= qidx;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {6'd0, out_echo, out_value};

endmodule

FILE: verif/tb_multi_queue_shared_memory_core.sv
`timescale 1ns / 100ps

module tb_multi_queue_shared_memory_core;
  import mqsm_pkg::*;

  localparam int NQ             = DEF_NUM_QUEUES;
  localparam int SEG            = DEF_SEGMENT_DEPTH;
  localparam int PTR_W          = (SEG > 1) ? $clog2(SEG) : 1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int BLOCK_ITEMS    = 60;
  localparam int NUM_BLOCKS     = 25;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [1:0]  echo;
  } reply_t;

  class queue_scoreboard;
    logic [31:0]      seg_mem [NQ*SEG];
    logic [PTR_W-1:0] head [NQ];
    logic [PTR_W-1:0] tail [NQ];
    logic             empty [NQ];
    reply_t           expected_replies [$];
    int               errors;

    function new();
      errors = 0;
      for (int q = 0; q < NQ; q++) begin
        head[q]  = '0;
        tail[q]  = '0;
        empty[q] = 1'b1;
      end
    endfunction

    function logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
      return (p == PTR_W'(SEG - 1)) ? '0 : p + 1'b1;
    endfunction

    // predict the reply of one accepted command and update the queue state
    function void note_command(logic cmd, logic [1:0] qi, logic [31:0] word);
      reply_t r;
      int     base;
      r.status = ST_OK;
      r.value  = '0;
      r.echo   = qi;
      if (int'(qi) >= NQ) begin
        r.status = ST_BADQ;
      end else begin
        base = int'(qi) * SEG;
        if (cmd == CMD_ENQ) begin
          if (empty[qi]) begin
            // restart an empty queue at the base of its segment
            head[qi]       = '0;
            tail[qi]       = '0;
            empty[qi]      = 1'b0;
            seg_mem[base]  = word;
          end else if (next_ptr(tail[qi]) == head[qi]) begin
            r.status = ST_FULL;
          end else begin
            tail[qi] = next_ptr(tail[qi]);
            seg_mem[base + int'(tail[qi])] = word;
          end
        end else begin
          if (empty[qi]) begin
            r.status = ST_EMPTY;
          end else begin
            r.value = seg_mem[base + int'(head[qi])];
            if (head[qi] == tail[qi]) empty[qi] = 1'b1;
            else head[qi] = next_ptr(head[qi]);
          end
        end
      end
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic [1:0] status, logic [31:0] value, logic [1:0] echo);
      reply_t r;
      if (expected_replies.size() == 0) begin
        $error("reply beat with no command pending: status %0d value %h queue %0d",
               status, value, echo);
        errors++;
        return;
      end
      r = expected_replies.pop_front();
      if (status !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, status);
        errors++;
      end
      if (value !== r.value) begin
        $error("dequeued_value: expected %h, actual %h", r.value, value);
        errors++;
      end
      if (echo !== r.echo) begin
        $error("queue_echo: expected %0d, actual %0d", r.echo, echo);
        errors++;
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // queue_index[1:0], value[33:2], zero pad
  logic        s_tuser  = 1'b0; // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // dequeued_value[31:0], queue_echo[33:32], zero pad
  logic [1:0]  m_tuser;         // status

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;

  queue_scoreboard sb = new();

  multi_queue_shared_memory_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // signals settle by the falling edge; a beat seen here is taken at the next rise
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_command(s_tuser, s_tdata[1:0], s_tdata[33:2]);
      if (m_tvalid && m_tready) sb.check_reply(m_tuser, m_tdata[31:0], m_tdata[33:32]);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_command(input logic cmd, input logic [1:0] qi, input logic [31:0] word);
    logic taken;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'd0, word, qi};
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int          enq_pct;
    logic [1:0]  hot_q;
    logic [1:0]  qi;
    logic        cmd;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty queues, extreme words, drain past empty, enqueue then dequeue at once
    for (int q = 0; q < NQ; q++) send_command(CMD_DEQ, 2'(q), 32'h0);
    send_command(CMD_ENQ, 2'd0, 32'h8000_0000);
    send_command(CMD_ENQ, 2'd0, 32'h7FFF_FFFF);
    send_command(CMD_ENQ, 2'd1, 32'h0000_0000);
    send_command(CMD_ENQ, 2'd2, 32'hFFFF_FFFF);
    send_command(CMD_ENQ, 2'd3, 32'h5555_5555);
    send_command(CMD_ENQ, 2'd3, 32'hAAAA_AAAA);
    repeat (3) send_command(CMD_DEQ, 2'd0, 32'hFFFF_FFFF);
    send_command(CMD_DEQ, 2'd1, 32'h0);
    send_command(CMD_DEQ, 2'd2, 32'h0);
    repeat (3) send_command(CMD_DEQ, 2'd3, 32'h0);
    send_command(CMD_ENQ, 2'd1, 32'h1234_5678);
    send_command(CMD_DEQ, 2'd1, 32'h0);

    // random: blocks that fill, churn or drain, mostly on one queue
    for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
      case (blk % 4)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 58; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 58; end
        default: begin src_idle_pct = 9;  snk_stall_pct = 9;  end
      endcase
      if (blk == 4) hold_requests++;
      case ($urandom_range(0, 2))
        0:       enq_pct = 90;
        1:       enq_pct = 50;
        default: enq_pct = 10;
      endcase
      hot_q = 2'($urandom_range(0, NQ - 1));
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        qi  = ($urandom_range(0, 99) < 75) ? hot_q : 2'($urandom_range(0, NQ - 1));
        cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
        send_command(cmd, qi, pick_word());
      end
    end

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
